/* rtl/sha1md_pkg.sv */
// Shared constants for the SHA-1 digest engine.
package sha1md_pkg;

  localparam int ROUNDS     = 80;
  localparam int LEN_POS    = 56;  // first byte of the length field in the last block
  localparam int NUM_WORDS  = 5;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] IV [NUM_WORDS] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

endpackage

/* rtl/sha1_message_digest_top.sv */
// SHA-1 engine: byte intake, padding, iterative 80-round compression, digest readout.
// Intake: a byte that does not fill a block is simply stored; the 64th byte of a block
//   starts the compression (load, 80 rounds on one shared round adder, chain update).
// End of message: up to 64 pad bytes at one per cycle, then compression of each padded block
//   (two blocks when fewer than 9 bytes are left), then 5 digest words.
// No byte is taken while a block is compressed, since there is a single round datapath.
// Reset (sync, rst_n low): chain value to the SHA-1 IV, byte count zero, idle;
//   block buffer and round variables are not cleared.
module sha1_message_digest_top #(
  parameter int LENGTH_WIDTH = 61
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_value,
  input  logic        in_byte_valid,
  input  logic        in_end_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_ADD, ST_OUT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [LENGTH_WIDTH-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [31:0]             h_r [sha1md_pkg::NUM_WORDS];
  logic [31:0]             h_nxt [sha1md_pkg::NUM_WORDS];
  logic [6:0]              rnd_r, rnd_nxt;
  logic [5:0]              pos_r, pos_nxt;
  logic                    pad_r, pad_nxt;
  logic                    fin_r, fin_nxt;
  logic                    first_r, first_nxt;
  logic [2:0]              oidx_r, oidx_nxt;

  // datapath, no reset
  logic [511:0] blk_r, blk_nxt;
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [31:0]  a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;

  logic        accept_in;
  logic [63:0] bitlen;
  logic [5:0]  lsel;
  logic [7:0]  pad_val;
  logic [31:0] w_mix, w_t, f_t, k_t, t_sum;

  assign in_ready        = (state_r == ST_IDLE);
  assign accept_in       = in_valid && in_ready;
  assign out_valid       = (state_r == ST_OUT);
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'(sha1md_pkg::NUM_WORDS - 1));

  assign cnt_inc = cnt_r + LENGTH_WIDTH'(1);
  assign bitlen  = 64'(cnt_r) << 3;
  assign lsel    = {~pos_r[2:0], 3'b000};

  always_comb begin
    if (first_r) begin
      pad_val = sha1md_pkg::PAD_BYTE;
    end else if (fin_r && (pos_r >= 6'(sha1md_pkg::LEN_POS))) begin
      pad_val = bitlen[lsel +: 8];  // big-endian bit length
    end else begin
      pad_val = 8'h00;
    end
  end

  // schedule taps: window word 0 is w[t-16]
  assign w_mix = blk_r[511:480] ^ blk_r[447:416] ^ blk_r[255:224] ^ blk_r[95:64];
  assign w_t   = (rnd_r < 7'd16) ? blk_r[511:480] : {w_mix[30:0], w_mix[31]};

  always_comb begin
    if (rnd_r < 7'd20) begin
      f_t = (b_r & c_r) | (~b_r & d_r);
      k_t = sha1md_pkg::K0;
    end else if (rnd_r < 7'd40) begin
      f_t = b_r ^ c_r ^ d_r;
      k_t = sha1md_pkg::K1;
    end else if (rnd_r < 7'd60) begin
      f_t = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_t = sha1md_pkg::K2;
    end else begin
      f_t = b_r ^ c_r ^ d_r;
      k_t = sha1md_pkg::K3;
    end
  end

  assign t_sum = {a_r[26:0], a_r[31:27]} + f_t + e_r + k_t + w_t;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    h_nxt     = h_r;
    rnd_nxt   = rnd_r;
    pos_nxt   = pos_r;
    pad_nxt   = pad_r;
    fin_nxt   = fin_r;
    first_nxt = first_r;
    oidx_nxt  = oidx_r;
    blk_nxt   = blk_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    e_nxt     = e_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept_in) begin
          pad_nxt   = in_end_message;
          first_nxt = 1'b1;
          if (in_byte_valid) begin
            blk_nxt = {blk_r[503:0], in_byte_value};
            cnt_nxt = cnt_inc;
            pos_nxt = cnt_inc[5:0];
            fin_nxt = (cnt_inc[5:0] < 6'(sha1md_pkg::LEN_POS));
            if (cnt_r[5:0] == 6'h3f) begin
              state_nxt = ST_LOAD;
            end else if (in_end_message) begin
              state_nxt = ST_PAD;
            end
          end else begin
            pos_nxt = cnt_r[5:0];
            fin_nxt = (cnt_r[5:0] < 6'(sha1md_pkg::LEN_POS));
            if (in_end_message) begin
              state_nxt = ST_PAD;
            end
          end
        end
      end
      ST_PAD: begin
        blk_nxt   = {blk_r[503:0], pad_val};
        first_nxt = 1'b0;
        pos_nxt   = pos_r + 6'd1;
        if (pos_r == 6'h3f) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        a_nxt     = h_r[0];
        b_nxt     = h_r[1];
        c_nxt     = h_r[2];
        d_nxt     = h_r[3];
        e_nxt     = h_r[4];
        rnd_nxt   = 7'd0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        blk_nxt = {blk_r[479:0], w_t};
        a_nxt   = t_sum;
        b_nxt   = a_r;
        c_nxt   = {b_r[1:0], b_r[31:2]};
        d_nxt   = c_r;
        e_nxt   = d_r;
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == 7'(sha1md_pkg::ROUNDS - 1)) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        h_nxt[0] = h_r[0] + a_r;
        h_nxt[1] = h_r[1] + b_r;
        h_nxt[2] = h_r[2] + c_r;
        h_nxt[3] = h_r[3] + d_r;
        h_nxt[4] = h_r[4] + e_r;
        if (!pad_r) begin
          state_nxt = ST_IDLE;
        end else if (first_r) begin
          // closing byte filled the block: the whole pad block is still to come
          state_nxt = ST_PAD;
        end else if (fin_r) begin
          oidx_nxt  = 3'd0;
          state_nxt = ST_OUT;
        end else begin
          // length did not fit: one more block of zeros and length
          fin_nxt   = 1'b1;
          state_nxt = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          if (out_last_word) begin
            h_nxt     = sha1md_pkg::IV;
            cnt_nxt   = '0;
            pad_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            oidx_nxt = oidx_r + 3'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      h_r     <= sha1md_pkg::IV;
      rnd_r   <= '0;
      pos_r   <= '0;
      pad_r   <= 1'b0;
      fin_r   <= 1'b0;
      first_r <= 1'b0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      h_r     <= h_nxt;
      rnd_r   <= rnd_nxt;
      pos_r   <= pos_nxt;
      pad_r   <= pad_nxt;
      fin_r   <= fin_nxt;
      first_r <= first_nxt;
      oidx_r  <= oidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    e_r   <= e_nxt;
  end

  a_no_intake_during_readout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted while digest words pending");

  a_idle_after_last_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_word) |=> (in_ready && cnt_r == '0))
    else $error("engine not back to initial state after digest");

  a_round_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (rnd_r < 7'(sha1md_pkg::ROUNDS)))
    else $error("round counter overran");

  a_readout_only_when_padded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD && !pad_r) |=> !out_valid)
    else $error("digest emitted without end of message");

endmodule
